FILE: hw/rtl/circular_double_ended_queue_assert.svh
// Assertion helpers shared by the queue RTL.
`ifndef CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define CIRCULAR_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define CDEQ_ASSERT_HOLDS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// A condition that implies another in the same cycle.
`define CDEQ_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// A condition that implies another in the following cycle.
`define CDEQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/cdeq_pkg.sv
`default_nettype none

package cdeq_pkg;

   localparam int VALUE_W     = 32;
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int RSP_COUNT_W = 8;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

`default_nettype wire

FILE: hw/rtl/cdeq_req_if.sv
`default_nettype none

interface cdeq_req_if;
   import cdeq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           operation;
   logic signed [VALUE_W-1:0] push_value;

   modport source (output valid, output operation, output push_value, input ready);
   modport sink   (input valid, input operation, input push_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cdeq_rsp_if.sv
`default_nettype none

interface cdeq_rsp_if;
   import cdeq_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic [RSP_COUNT_W-1:0]    entry_count;
   logic signed [VALUE_W-1:0] front_value;
   logic signed [VALUE_W-1:0] rear_value;

   modport source (output valid, output status, output entry_count,
                   output front_value, output rear_value, input ready);
   modport sink   (input valid, input status, input entry_count,
                   input front_value, input rear_value, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/cdeq_ram.sv
`default_nettype none

module cdeq_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [AW-1:0]               wr_addr,
   input  wire logic [cdeq_pkg::VALUE_W-1:0] wr_data,
   input  wire logic [AW-1:0]               rd_addr,
   output      logic [cdeq_pkg::VALUE_W-1:0] rd_data
);
   import cdeq_pkg::*;

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/circular_double_ended_queue.sv
// A result is registered in the cycle after its request is accepted; a pop that
// leaves two or more entries behind first waits on the entry store read, and its
// result is registered from the read data. Throughput: one transaction per cycle when
// the output is not held; such pops stall requests while the single store read port
// fetches the new front or rear value. Reset is synchronous and active high: it
// empties the queue and drops any pending result; the entry store is not cleared.
`default_nettype none
`include "circular_double_ended_queue_assert.svh"

module circular_double_ended_queue #(
   parameter int DEPTH = 128
) (
   input wire logic  clock,
   input wire logic  reset,
   cdeq_req_if.sink   req_bus,
   cdeq_rsp_if.source rsp_bus
);
   import cdeq_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == LAST_IDX) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] p);
      return (p == '0) ? LAST_IDX : p - AW'(1);
   endfunction

   function automatic logic [RSP_COUNT_W-1:0] mask_count(input logic [CW-1:0] c);
      logic [CW+RSP_COUNT_W-1:0] ext;
      ext = {{RSP_COUNT_W{1'b0}}, c};
      return ext[RSP_COUNT_W-1:0];
   endfunction

   logic [AW-1:0]      head_ff, head_in;
   logic [AW-1:0]      tail_ff, tail_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [VALUE_W-1:0] front_ff, front_in;
   logic [VALUE_W-1:0] rear_ff, rear_in;
   logic               pend_ff;
   logic               pend_front_ff;

   logic                   rsp_valid_ff;
   logic [STATUS_W-1:0]    rsp_status_ff;
   logic [RSP_COUNT_W-1:0] rsp_count_ff;
   logic [VALUE_W-1:0]     rsp_front_ff;
   logic [VALUE_W-1:0]     rsp_rear_ff;

   logic               accept;
   status_type         status;
   logic               need_read;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic [VALUE_W-1:0] push_bits;

   assign req_bus.ready = !pend_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign push_bits     = req_bus.push_value;

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      front_in  = front_ff;
      rear_in   = rear_ff;
      status    = ST_DONE;
      need_read = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = head_ff;
      rd_addr   = head_ff;

      unique case (op_type'(req_bus.operation))
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (count_ff == FULL_CNT) begin
               status = ST_FULL;
            end else begin
               wr_en    = accept;
               count_in = count_ff + CW'(1);
               if (count_ff == '0) begin
                  head_in  = '0;
                  tail_in  = '0;
                  wr_addr  = '0;
                  front_in = push_bits;
                  rear_in  = push_bits;
               end else if (op_type'(req_bus.operation) == OP_PUSH_FRONT) begin
                  head_in  = wrap_dec(head_ff);
                  wr_addr  = head_in;
                  front_in = push_bits;
               end else begin
                  tail_in  = wrap_inc(tail_ff);
                  wr_addr  = tail_in;
                  rear_in  = push_bits;
               end
            end
         end
         OP_POP_FRONT, OP_POP_REAR: begin
            if (count_ff == '0) begin
               status = ST_EMPTY;
            end else if (count_ff == CW'(1)) begin
               count_in = '0;
               head_in  = '0;
               tail_in  = '0;
            end else begin
               count_in = count_ff - CW'(1);
               if (op_type'(req_bus.operation) == OP_POP_FRONT) begin
                  head_in  = wrap_inc(head_ff);
                  rd_addr  = head_in;
                  // With one entry left, the new front is the cached rear value.
                  front_in = rear_ff;
               end else begin
                  tail_in  = wrap_dec(tail_ff);
                  rd_addr  = tail_in;
                  rear_in  = front_ff;
               end
               need_read = (count_ff != CW'(2));
            end
         end
      endcase
   end

   cdeq_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (push_bits),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= accept && need_read;
         if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
         if (pend_ff || (accept && !need_read)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         // The fetched entry completes the pop that is waiting on the store.
         rsp_status_ff <= ST_DONE;
         rsp_count_ff  <= mask_count(count_ff);
         if (pend_front_ff) begin
            front_ff     <= rd_data;
            rsp_front_ff <= rd_data;
            rsp_rear_ff  <= rear_ff;
         end else begin
            rear_ff      <= rd_data;
            rsp_front_ff <= front_ff;
            rsp_rear_ff  <= rd_data;
         end
      end else if (accept) begin
         front_ff      <= front_in;
         rear_ff       <= rear_in;
         pend_front_ff <= (op_type'(req_bus.operation) == OP_POP_FRONT);
         if (!need_read) begin
            rsp_status_ff <= status;
            rsp_count_ff  <= mask_count(count_in);
            rsp_front_ff  <= (count_in != '0) ? front_in : '0;
            rsp_rear_ff   <= (count_in != '0) ? rear_in : '0;
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.entry_count = rsp_count_ff;
   assign rsp_bus.front_value = rsp_front_ff;
   assign rsp_bus.rear_value  = rsp_rear_ff;

   `CDEQ_ASSERT_HOLDS(a_count_bound, clock, reset, count_ff <= FULL_CNT, "count above depth")
   `CDEQ_ASSERT_IMPLIES(a_empty_idx, clock, reset, count_ff == '0,
      (head_ff == '0) && (tail_ff == '0), "empty queue with nonzero index")
   `CDEQ_ASSERT_IMPLIES(a_pend_slot, clock, reset, pend_ff, !rsp_valid_ff,
      "store read returned while output slot busy")
   `CDEQ_ASSERT_NEXT(a_read_issue, clock, reset, accept && need_read, pend_ff,
      "pop needing a store read did not wait for it")
   `CDEQ_ASSERT_NEXT(a_pend_once, clock, reset, pend_ff, !pend_ff,
      "store read wait lasted more than one cycle")

endmodule

`default_nettype wire
